/* rtl/oaht_pkg.sv */
// Package with the word types, codes and controller types of the hash table.
`timescale 1ns / 1ps
package oaht_pkg;

  localparam int KEY_W    = 31;
  localparam int SIZE_W   = 7;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int DIV_CW   = 5;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_PROBE_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_INSERTED  = 3'd0,
    RS_FOUND     = 3'd1,
    RS_NOT_FOUND = 3'd2,
    RS_FULL      = 3'd3,
    RS_NO_SLOT   = 3'd4,
    RS_CLEARED   = 3'd5
  } res_status_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_HIT  = 2'd1,
    SEL_MISS = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] probe_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_SETUP,
    ST_PROBE,
    ST_CHECK,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic        load;
    logic        clear;
    logic        div_start;
    logic        div_step;
    logic        probe_init;
    logic        probe_adv;
    logic        ins_write;
    logic        res_set;
    res_status_t res_code;
    res_sel_t    res_sel;
    logic        out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic div_last;
    logic hit;
    logic last_probe;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/oaht_ctrl.sv */
// Controller state machine that sequences the divide and probe steps.
`timescale 1ns / 1ps
module oaht_ctrl import oaht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_code = RS_NOT_FOUND;
    cmd.res_sel  = SEL_ZERO;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = RS_CLEARED;
            state_nxt    = ST_FINISH;
          end
          OP_NONE: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = RS_NOT_FOUND;
            state_nxt    = ST_FINISH;
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = RS_FULL;
              state_nxt    = ST_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          default: begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.probe_init = 1'b1;
        state_nxt      = ST_PROBE;
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts.hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_sel  = SEL_HIT;
          cmd.ins_write = (sts.op == OP_INSERT);
          cmd.res_code = (sts.op == OP_INSERT) ? RS_INSERTED : RS_FOUND;
          state_nxt    = ST_FINISH;
        end else if (sts.last_probe) begin
          cmd.res_set  = 1'b1;
          cmd.res_sel  = SEL_MISS;
          cmd.res_code = (sts.op == OP_INSERT) ? RS_NO_SLOT : RS_NOT_FOUND;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = ST_PROBE;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/oaht_dp.sv */
// Datapath: configuration, divider, probe address unit, slot store and output register.
`timescale 1ns / 1ps
module oaht_dp import oaht_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts
);

  // Only slots below the largest table_size can ever be probed.
  localparam int UD = (TABLE_DEPTH < (1 << SIZE_W)) ? TABLE_DEPTH : (1 << SIZE_W);
  localparam int AW = (UD > 1) ? $clog2(UD) : 1;

  logic [SIZE_W-1:0]  table_size_r;
  logic               probe_mode_r;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [SIZE_W-1:0]  size_r;
  logic [DIV_CW-1:0]  div_cnt_r;
  logic [KEY_W-1:0]   dvd_r;
  logic [SIZE_W-1:0]  rem_r, rem_nxt;
  logic [SIZE_W-1:0]  r2_r, r2_nxt;
  logic [SIZE_W-1:0]  idx_r, idx_nxt;
  logic [SIZE_W-1:0]  step_r;
  logic [COUNT_W-1:0] n_r;
  logic [SIZE_W-1:0]  count_r;
  logic               used_r [UD];
  logic [KEY_W-1:0]   mem [UD];
  logic [KEY_W-1:0]   key_rd_r;
  out_word_t          res_r, out_r;
  logic               out_valid_r;
  logic [SIZE_W-1:0]  eff_size;
  logic [SIZE_W:0]    rem_sh, r2_sh, idx_sum;
  logic               qbit;
  logic [AW-1:0]      addr;

  assign addr = AW'(idx_r);

  always_comb begin
    eff_size = table_size_r;
    if (table_size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size_r) > TABLE_DEPTH) begin
      eff_size = SIZE_W'(TABLE_DEPTH);
    end
  end

  // One quotient bit per step; the quotient's remainder runs alongside.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[KEY_W-1]};
    qbit    = (rem_sh >= {1'b0, size_r});
    rem_nxt = qbit ? SIZE_W'(rem_sh - {1'b0, size_r}) : rem_sh[SIZE_W-1:0];
    r2_sh   = {r2_r, qbit};
    r2_nxt  = (r2_sh >= {1'b0, size_r}) ? SIZE_W'(r2_sh - {1'b0, size_r})
                                        : r2_sh[SIZE_W-1:0];
    idx_sum = {1'b0, idx_r} + {1'b0, step_r};
    idx_nxt = (idx_sum >= {1'b0, size_r}) ? SIZE_W'(idx_sum - {1'b0, size_r})
                                          : idx_sum[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_W'(64);
      probe_mode_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TABLE_SIZE) begin
        table_size_r <= cfg_data;
      end else begin
        probe_mode_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_data.mode);
      key_r  <= in_data.key;
      size_r <= eff_size;
    end
    if (cmd.div_start) begin
      dvd_r     <= key_r;
      rem_r     <= '0;
      r2_r      <= '0;
      div_cnt_r <= DIV_CW'(KEY_W - 1);
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[KEY_W-2:0], 1'b0};
      rem_r     <= rem_nxt;
      r2_r      <= r2_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (cmd.probe_init) begin
      idx_r  <= rem_r;
      step_r <= (!probe_mode_r || r2_r == '0) ? SIZE_W'(1) : r2_r;
      n_r    <= COUNT_W'(1);
    end else if (cmd.probe_adv) begin
      idx_r <= idx_nxt;
      n_r   <= n_r + 1'b1;
    end
    if (cmd.res_set) begin
      res_r.status <= cmd.res_code;
      unique case (cmd.res_sel)
        SEL_HIT: begin
          res_r.slot        <= idx_r[SLOT_W-1:0];
          res_r.probe_count <= n_r;
        end
        SEL_MISS: begin
          res_r.slot        <= '0;
          res_r.probe_count <= COUNT_W'(size_r);
        end
        default: begin
          res_r.slot        <= '0;
          res_r.probe_count <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < UD; i++) begin
        used_r[i] <= 1'b0;
      end
    end else if (cmd.clear) begin
      count_r <= '0;
      for (int i = 0; i < UD; i++) begin
        used_r[i] <= 1'b0;
      end
    end else if (cmd.ins_write) begin
      count_r      <= count_r + 1'b1;
      used_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem[addr] <= key_r;
    end
    key_rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.op         = op_r;
    sts.full       = (count_r >= size_r);
    sts.div_last   = (div_cnt_r == '0);
    sts.hit        = (op_r == OP_INSERT) ? !used_r[addr]
                                         : (used_r[addr] && key_rd_r == key_r);
    sts.last_probe = (n_r == COUNT_W'(size_r));
    sts.out_free   = !out_valid_r || out_ready;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_adv |=> idx_r < size_r)
    else $error("probe index left the table");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_init |-> (rem_r < size_r && r2_r < size_r))
    else $error("hash remainder out of range");

  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> !used_r[addr])
    else $error("insert overwrote an occupied slot");

endmodule

/* rtl/open_address_hash_table.sv */
// Top level of the open-addressing hash table: controller plus datapath.
// Usage: each input word carries a mode (insert, look up, clear) and a 31-bit
// key, and yields exactly one result word with status, slot and probe count.
// Both channels use valid/ready; a word moves when both are high.
// The configuration port (cfg_we, cfg_index, cfg_data) sets table_size and
// probe_mode and should only be written while the block is idle.
// Clear, the unused mode and a dropped insert on a full table go from dispatch
// straight to the output register. Insert and lookup run a one-bit-per-cycle
// divider over the 31 key bits to form the home slot and the double-hash step,
// then for each probe read the slot store and then compare before the result
// reaches the output register.
// One word is worked on at a time; the next word is taken once the previous
// result has entered the output register, even if it is not yet taken.
// When the receiver stalls, the result holds in the output register and the
// next word finishes its work and then waits for that register to drain.
// Reset empties every slot at once, zeroes the stored-key count and sets
// table_size to 64 and probe_mode to double hashing.
`timescale 1ns / 1ps
module open_address_hash_table import oaht_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller only steps the sequence; all arithmetic and storage
  // live in the datapath.
  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oaht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* dv/tb_open_address_hash_table.sv */
// Self-checking testbench for the open-addressing hash table top level.
`timescale 1ns / 1ps
module tb_open_address_hash_table;
  import oaht_pkg::*;

  localparam int DEPTH      = 64;
  localparam int PHASE_LEN  = 183;
  localparam int HANG_LIMIT = 6000;
  // Worst-case work for one word plus the output stage fits well inside this
  // pause, so it is long enough for the block to settle.
  localparam int SETTLE_CYCLES = 250;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;

  open_address_hash_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Words waiting to be sent and results the table is expected to return.
  in_word_t  request_words[$];
  out_word_t expected_results[$];
  int unsigned known_keys[$];

  // Our own copy of the table state and its two registers.
  logic [KEY_W-1:0] model_keys[DEPTH];
  logic             model_used[DEPTH];
  int unsigned      model_count;
  int unsigned      model_size;
  logic             model_double;

  int  idle_pct  = 0;
  int  stall_pct = 0;
  bit  failed    = 1'b0;
  int  quiet_cycles = 0;

  initial forever #4 clk = ~clk;

  // Looks up or updates the shadow table for one accepted word and returns
  // the result the block should produce for it.
  function automatic out_word_t predict_lookup_result(in_word_t w);
    int unsigned sz, step, idx, n, k;
    bit done;
    out_word_t r;
    r = '0;
    sz = (model_size == 0) ? 1 : ((model_size > DEPTH) ? DEPTH : model_size);
    k = 32'(w.key);
    done = 1'b0;
    if (op_t'(w.mode) == OP_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) model_used[i] = 1'b0;
      model_count = 0;
      r.status = RS_CLEARED;
    end else if (op_t'(w.mode) == OP_NONE) begin
      r.status = RS_NOT_FOUND;
    end else begin
      // Linear mode and small keys step by one; a zero double-hash step is
      // bumped to one so the probe sequence always moves.
      step = (!model_double || k < sz) ? 1 : (k / sz) % sz;
      if (step == 0) step = 1;
      idx = k % sz;
      if (op_t'(w.mode) == OP_INSERT) begin
        if (model_count >= sz) begin
          r.status = RS_FULL;
        end else begin
          r.status = RS_NO_SLOT;
          r.probe_count = COUNT_W'(sz);
          for (n = 1; n <= sz; n++) begin
            if (!done && !model_used[idx]) begin
              model_used[idx] = 1'b1;
              model_keys[idx] = KEY_W'(k);
              model_count = (model_count + 1) & 7'h7f;
              r.status = RS_INSERTED;
              r.slot = SLOT_W'(idx);
              r.probe_count = COUNT_W'(n);
              done = 1'b1;
            end
            idx = (idx + step) % sz;
          end
        end
      end else begin
        // Empty slots do not stop a lookup; only a match or the probe bound.
        r.status = RS_NOT_FOUND;
        r.probe_count = COUNT_W'(sz);
        for (n = 1; n <= sz; n++) begin
          if (!done && model_used[idx] && model_keys[idx] == KEY_W'(k)) begin
            r.status = RS_FOUND;
            r.slot = SLOT_W'(idx);
            r.probe_count = COUNT_W'(n);
            done = 1'b1;
          end
          idx = (idx + step) % sz;
        end
      end
    end
    return r;
  endfunction

  // Driver: a new word is offered only when the previous one has moved, so
  // valid and the payload stay put until the handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on every accepted input word, check every result word.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_results = {expected_results, predict_lookup_result(in_data)};
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, out_data);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
            failed = 1'b1;
          end
          if (out_data.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_data.slot);
            failed = 1'b1;
          end
          if (out_data.probe_count !== want.probe_count) begin
            $display("%0t: probe_count expected %0d actual %0d", $time,
                     want.probe_count, out_data.probe_count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: the run is stuck if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_word(op_t op, int unsigned key);
    in_word_t w;
    w.mode = op;
    w.key = KEY_W'(key);
    request_words = {request_words, w};
  endtask

  // Both registers are written on back-to-back edges; the enable is lowered
  // only after the second write so it gets one assignment per edge.
  task automatic set_config(int unsigned size, bit dbl);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TABLE_SIZE;
    cfg_data <= SIZE_W'(size);
    model_size = size;
    @(posedge clk);
    cfg_index <= CFG_PROBE_MODE;
    cfg_data <= {{(SIZE_W-1){1'b0}}, dbl};
    model_double = dbl;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the caller until every word has gone out and every result is back.
  task automatic drain_and_settle();
    while (request_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random words: mostly inserts and lookups of small or already-stored keys
  // so that collisions and hits are common, with full-width keys, clears and
  // the unused mode mixed in.
  task automatic queue_random_words(int count);
    int unsigned sz, key, pick;
    sz = (model_size == 0) ? 1 : ((model_size > DEPTH) ? DEPTH : model_size);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) key = $urandom() & 32'h7fffffff;
      else key = $urandom_range(4 * sz * sz + 3);
      if (pick < 2) begin
        push_word(OP_CLEAR, key);
      end else if (pick < 4) begin
        push_word(OP_NONE, key);
      end else if (pick < 52) begin
        push_word(OP_INSERT, key);
        if (known_keys.size() < 200) known_keys = {known_keys, key};
      end else begin
        if (known_keys.size() > 0 && $urandom_range(9) < 7)
          key = known_keys[$urandom_range(known_keys.size() - 1)];
        push_word(OP_LOOKUP, key);
      end
    end
  endtask

  initial begin
    int unsigned sizes[9] = '{64, 1, 64, 0, 127, 13, 37, 64, 7};
    bit          modes[9] = '{1, 0, 0, 1, 1, 1, 0, 1, 1};
    for (int i = 0; i < DEPTH; i++) begin
      model_used[i] = 1'b0;
      model_keys[i] = '0;
    end
    model_count = 0;
    model_size = 64;
    model_double = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part on a four-slot double-hash table. Key 10 homes on slot 2
    // with step 2, so once slots 0 and 2 are taken its path has no room and a
    // lookup of it misses after all four probes.
    set_config(4, 1'b1);
    push_word(OP_INSERT, 2);
    push_word(OP_INSERT, 0);
    push_word(OP_INSERT, 10);
    push_word(OP_LOOKUP, 10);
    push_word(OP_LOOKUP, 0);
    push_word(OP_NONE, 31'h7fffffff);
    push_word(OP_INSERT, 31'h7fffffff);
    push_word(OP_INSERT, 2);
    push_word(OP_INSERT, 5);
    push_word(OP_LOOKUP, 31'h7fffffff);
    push_word(OP_LOOKUP, 2);
    push_word(OP_CLEAR, 0);
    push_word(OP_LOOKUP, 2);
    push_word(OP_INSERT, 8);
    drain_and_settle();

    // Random phases. The table is not cleared between them, so a shrink
    // leaves keys stranded above the new size. Idling cycles through none,
    // a slow sender, a slow receiver and both.
    for (int p = 0; p < 9; p++) begin
      set_config(sizes[p], modes[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      queue_random_words(PHASE_LEN);
      drain_and_settle();
    end

    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
